// ===== rtl/opbd_pkg.sv =====
// ----------------------------------------------------------------------------
// opbd_pkg
// Shared types, constants and the pulse window classifier for the OOK
// pulse-width bit decoder.
// ----------------------------------------------------------------------------
package opbd_pkg;

    localparam int MaxBytes   = 32;
    localparam int QueueDepth = 4;

    localparam int TimeW = 16;
    localparam int CfgIdxW = 2;

    localparam logic [TimeW-1:0] BitTimeRst   = 16'd500;
    localparam logic [TimeW-1:0] ToleranceRst = 16'd100;
    localparam logic [TimeW-1:0] StartTimeRst = 16'd2000;

    typedef enum logic [1:0] {
        SYM_INVALID = 2'd0,
        SYM_ZERO    = 2'd1,
        SYM_ONE     = 2'd2,
        SYM_START   = 2'd3
    } t_symbol;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BIT_TIME   = 2'd0,
        CFG_TOLERANCE  = 2'd1,
        CFG_START_TIME = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        RX_IDLE   = 1'b0,
        RX_ACTIVE = 1'b1
    } t_rx_state;

    // Symbol handoff from the classifier to the frame logic
    typedef struct packed {
        logic    valid;
        t_symbol sym;
    } t_sym_xfer;

    // n - d <= t < n + d, rewritten as t + d >= n so nothing goes negative
    function automatic logic in_window(
        input logic [TimeW-1:0] t,
        input logic [TimeW:0]   n,
        input logic [TimeW-1:0] d
    );
        logic [TimeW+1:0] lo_sum;
        logic [TimeW+1:0] hi_sum;
        lo_sum = {2'b00, t} + {2'b00, d};
        hi_sum = {1'b0, n} + {2'b00, d};
        return (lo_sum >= {1'b0, n}) && ({2'b00, t} < hi_sum);
    endfunction

    function automatic t_symbol classify(
        input logic [TimeW-1:0] t,
        input logic [TimeW-1:0] bit_time,
        input logic [TimeW-1:0] tolerance,
        input logic [TimeW-1:0] start_time
    );
        t_symbol s;
        if (in_window(t, {1'b0, bit_time}, tolerance)) begin
            s = SYM_ZERO;
        end else if (in_window(t, {bit_time, 1'b0}, tolerance)) begin
            s = SYM_ONE;
        end else if (in_window(t, {1'b0, start_time}, tolerance)) begin
            s = SYM_START;
        end else begin
            s = SYM_INVALID;
        end
        return s;
    endfunction

endpackage

// ===== rtl/opbd_pulse_if.sv =====
// ----------------------------------------------------------------------------
// opbd_pulse_if
// Pulse duration channel: valid/ready with one measured duration.
// ----------------------------------------------------------------------------
interface opbd_pulse_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_time;

    modport source (output valid, output pulse_time, input ready);
    modport sink   (input valid, input pulse_time, output ready);
endinterface

// ===== rtl/opbd_result_if.sv =====
// ----------------------------------------------------------------------------
// opbd_result_if
// Result channel: valid/ready with the decoded symbol and frame status.
// ----------------------------------------------------------------------------
interface opbd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       receiving;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [4:0] byte_index;
    logic       overflow;
    logic [7:0] error_count;
    logic [7:0] restart_count;

    modport source (
        output valid, output symbol, output receiving, output byte_valid,
        output byte_value, output byte_index, output overflow,
        output error_count, output restart_count, input ready
    );
    modport sink (
        input valid, input symbol, input receiving, input byte_valid,
        input byte_value, input byte_index, input overflow,
        input error_count, input restart_count, output ready
    );
endinterface

// ===== rtl/opbd_classify.sv =====
// ----------------------------------------------------------------------------
// opbd_classify
// Front stage: accepts a pulse duration and registers its window class.
// ----------------------------------------------------------------------------
module opbd_classify (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    opbd_pulse_if.sink                i_pulse,
    input  logic [opbd_pkg::TimeW-1:0] i_bit_time,
    input  logic [opbd_pkg::TimeW-1:0] i_tolerance,
    input  logic [opbd_pkg::TimeW-1:0] i_start_time,
    output opbd_pkg::t_sym_xfer       o_sym,
    input  logic                      i_sym_ready
);

    logic              r_valid;
    opbd_pkg::t_symbol r_sym;
    logic              take;

    assign i_pulse.ready = !r_valid || i_sym_ready;
    assign take          = i_pulse.valid && i_pulse.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pulse.ready) begin
            r_valid <= i_pulse.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sym <= opbd_pkg::classify(i_pulse.pulse_time, i_bit_time,
                                        i_tolerance, i_start_time);
        end
    end

    assign o_sym.valid = r_valid;
    assign o_sym.sym   = r_sym;

endmodule

// ===== rtl/opbd_queue.sv =====
// ----------------------------------------------------------------------------
// opbd_queue
// Small symbol FIFO between the classifier and the frame logic.
// ----------------------------------------------------------------------------
module opbd_queue #(
    parameter int DEPTH = opbd_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  opbd_pkg::t_sym_xfer i_push,
    output logic                o_push_ready,
    output opbd_pkg::t_sym_xfer o_pop,
    input  logic                i_pop_ready
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    opbd_pkg::t_symbol r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign push         = i_push.valid && o_push_ready;
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.sym    = r_mem[r_rd_ptr];
    assign pop          = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.sym;
        end
    end

endmodule

// ===== rtl/opbd_frame.sv =====
// ----------------------------------------------------------------------------
// opbd_frame
// Back stage: frame state machine, bit packing, counters and result register.
// ----------------------------------------------------------------------------
module opbd_frame #(
    parameter int MAX_BYTES = opbd_pkg::MaxBytes
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  opbd_pkg::t_sym_xfer i_sym,
    output logic                o_sym_ready,
    opbd_result_if.source       o_result
);

    localparam int CntW = $clog2(MAX_BYTES + 1);

    opbd_pkg::t_rx_state r_state, n_state;
    logic [2:0]          r_bit_pos, n_bit_pos;
    logic [7:0]          r_partial, n_partial;
    logic [CntW-1:0]     r_bytes, n_bytes;
    logic [7:0]          r_errors, n_errors;
    logic [7:0]          r_restarts, n_restarts;

    logic       r_ovalid;
    logic [1:0] r_symbol;
    logic       r_receiving;
    logic       r_byte_valid, n_byte_valid;
    logic [7:0] r_byte_value, n_byte_value;
    logic [4:0] r_byte_index, n_byte_index;
    logic       r_overflow, n_overflow;

    logic            take;
    logic [7:0]      packed_byte;
    logic [CntW+4:0] bytes_wide;

    assign o_sym_ready = !r_ovalid || o_result.ready;
    assign take        = i_sym.valid && o_sym_ready;
    assign bytes_wide  = {5'd0, r_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= opbd_pkg::RX_IDLE;
            r_bit_pos  <= '0;
            r_partial  <= '0;
            r_bytes    <= '0;
            r_errors   <= '0;
            r_restarts <= '0;
        end else if (take) begin
            r_state    <= n_state;
            r_bit_pos  <= n_bit_pos;
            r_partial  <= n_partial;
            r_bytes    <= n_bytes;
            r_errors   <= n_errors;
            r_restarts <= n_restarts;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bit_pos    = r_bit_pos;
        n_partial    = r_partial;
        n_bytes      = r_bytes;
        n_errors     = r_errors;
        n_restarts   = r_restarts;
        n_byte_valid = 1'b0;
        n_byte_value = '0;
        n_byte_index = '0;
        n_overflow   = 1'b0;
        // MSB first: bit position 0 lands in bit 7
        packed_byte  = r_partial | ({7'd0, i_sym.sym == opbd_pkg::SYM_ONE}
                                    << (3'd7 - r_bit_pos));

        if (i_sym.sym == opbd_pkg::SYM_START) begin
            n_state    = opbd_pkg::RX_ACTIVE;
            n_bit_pos  = '0;
            n_partial  = '0;
            n_bytes    = '0;
            n_restarts = r_restarts + 8'd1;
        end else begin
            case (r_state)
                opbd_pkg::RX_ACTIVE: begin
                    if (i_sym.sym == opbd_pkg::SYM_INVALID) begin
                        n_errors = r_errors + 8'd1;
                    end else if (r_bytes >= CntW'(MAX_BYTES)) begin
                        n_overflow = 1'b1;
                    end else if (r_bit_pos == 3'd7) begin
                        n_byte_valid = 1'b1;
                        n_byte_value = packed_byte;
                        n_byte_index = bytes_wide[4:0];
                        n_bytes      = r_bytes + 1'b1;
                        n_partial    = '0;
                        n_bit_pos    = '0;
                    end else begin
                        n_partial = packed_byte;
                        n_bit_pos = r_bit_pos + 3'd1;
                    end
                end
                default: begin
                    // idle: anything but a start mark is ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_sym_ready) begin
            r_ovalid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_symbol     <= i_sym.sym;
            r_receiving  <= (n_state == opbd_pkg::RX_ACTIVE);
            r_byte_valid <= n_byte_valid;
            r_byte_value <= n_byte_value;
            r_byte_index <= n_byte_index;
            r_overflow   <= n_overflow;
        end
    end

    assign o_result.valid         = r_ovalid;
    assign o_result.symbol        = r_symbol;
    assign o_result.receiving     = r_receiving;
    assign o_result.byte_valid    = r_byte_valid;
    assign o_result.byte_value    = r_byte_value;
    assign o_result.byte_index    = r_byte_index;
    assign o_result.overflow      = r_overflow;
    assign o_result.error_count   = r_errors;
    assign o_result.restart_count = r_restarts;

endmodule

// ===== rtl/ook_pulse_width_bit_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ook_pulse_width_bit_decoder_top
// OOK pulse-width decoder: classifies pulse durations and assembles bytes.
//
//   channel   dir  handshake       payload
//   i_pulse   in   valid/ready     pulse_time[15:0]
//   o_result  out  valid/ready     symbol, receiving, byte_*, overflow, counts
//   cfg       in   i_cfg_we only   i_cfg_idx[1:0], i_cfg_data[15:0]
//
// One item per cycle sustained while o_result is ready; each input transfer
// reaches o_result via the classifier register, queue entry and result register.
// The symbol queue lets the classifier keep taking pulses while the result
// side stalls, up to the queue depth plus the two stage registers.
// Reset is synchronous and clears the frame, counters and config to defaults.
// ----------------------------------------------------------------------------
module ook_pulse_width_bit_decoder_top #(
    parameter int MAX_BYTES   = opbd_pkg::MaxBytes,
    parameter int QUEUE_DEPTH = opbd_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    opbd_pulse_if.sink                    i_pulse,
    opbd_result_if.source                 o_result,
    input  logic                          i_cfg_we,
    input  logic [opbd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [opbd_pkg::TimeW-1:0]    i_cfg_data
);

    logic [opbd_pkg::TimeW-1:0] r_bit_time;
    logic [opbd_pkg::TimeW-1:0] r_tolerance;
    logic [opbd_pkg::TimeW-1:0] r_start_time;

    opbd_pkg::t_sym_xfer cls_sym;
    opbd_pkg::t_sym_xfer q_sym;
    logic                q_push_ready;
    logic                frm_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_time   <= opbd_pkg::BitTimeRst;
            r_tolerance  <= opbd_pkg::ToleranceRst;
            r_start_time <= opbd_pkg::StartTimeRst;
        end else if (i_cfg_we) begin
            case (opbd_pkg::t_cfg_idx'(i_cfg_idx))
                opbd_pkg::CFG_BIT_TIME:   r_bit_time   <= i_cfg_data;
                opbd_pkg::CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                opbd_pkg::CFG_START_TIME: r_start_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    opbd_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pulse      (i_pulse),
        .i_bit_time   (r_bit_time),
        .i_tolerance  (r_tolerance),
        .i_start_time (r_start_time),
        .o_sym        (cls_sym),
        .i_sym_ready  (q_push_ready)
    );

    opbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cls_sym),
        .o_push_ready (q_push_ready),
        .o_pop        (q_sym),
        .i_pop_ready  (frm_ready)
    );

    opbd_frame #(
        .MAX_BYTES (MAX_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym       (q_sym),
        .o_sym_ready (frm_ready),
        .o_result    (o_result)
    );

endmodule

// ===== test/opbd_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opbd_decode_checker
// Watches the pulse, result and config ports of the OOK pulse-width decoder,
// predicts the decoded result of every pulse transfer and compares each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module opbd_decode_checker
    import opbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    opbd_pulse_if              pulse_ch,
    opbd_result_if             result_ch,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [TimeW-1:0]   i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct packed {
        t_symbol    symbol;
        logic       receiving;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [4:0] byte_index;
        logic       overflow;
        logic [7:0] error_count;
        logic [7:0] restart_count;
    } t_decode;

    // Predictor copy of config and frame state
    logic [TimeW-1:0] bit_time;
    logic [TimeW-1:0] tolerance;
    logic [TimeW-1:0] start_time;
    t_rx_state        rx_state;
    logic [2:0]       bit_pos;
    logic [7:0]       shift_byte;
    logic [5:0]       byte_count;
    logic [7:0]       err_cnt;
    logic [7:0]       restart_cnt;

    t_decode decode_queue[$];
    t_decode oldest;
    int      pending_q  = 0;
    int      fail_total = 0;

    assign o_pending    = pending_q;
    assign o_fail_count = fail_total;

    // Lower bound may go negative, upper bound may exceed 16 bits
    function automatic logic hits(int t, int nominal);
        int d;
        d = int'(tolerance);
        return (t >= nominal - d) && (t < nominal + d);
    endfunction

    function automatic t_decode decode_pulse(logic [TimeW-1:0] pulse);
        t_decode r;
        t_symbol sym;
        int      tv;
        r  = '0;
        tv = int'(pulse);
        if (hits(tv, int'(bit_time))) begin
            sym = SYM_ZERO;
        end else if (hits(tv, 2 * int'(bit_time))) begin
            sym = SYM_ONE;
        end else if (hits(tv, int'(start_time))) begin
            sym = SYM_START;
        end else begin
            sym = SYM_INVALID;
        end

        if (sym == SYM_START) begin
            // start mark always (re)opens a frame
            bit_pos     = '0;
            shift_byte  = '0;
            byte_count  = '0;
            rx_state    = RX_ACTIVE;
            restart_cnt = restart_cnt + 8'd1;
        end else if (rx_state == RX_ACTIVE) begin
            if (sym == SYM_INVALID) begin
                err_cnt = err_cnt + 8'd1;
            end else if (byte_count >= MaxBytes) begin
                r.overflow = 1'b1;
            end else begin
                shift_byte[3'd7 - bit_pos] = (sym == SYM_ONE);
                if (bit_pos == 3'd7) begin
                    r.byte_valid = 1'b1;
                    r.byte_value = shift_byte;
                    r.byte_index = byte_count[4:0];
                    byte_count   = byte_count + 6'd1;
                    shift_byte   = '0;
                    bit_pos      = '0;
                end else begin
                    bit_pos = bit_pos + 3'd1;
                end
            end
        end

        r.symbol        = sym;
        r.receiving     = (rx_state == RX_ACTIVE);
        r.error_count   = err_cnt;
        r.restart_count = restart_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bit_time    <= BitTimeRst;
            tolerance   <= ToleranceRst;
            start_time  <= StartTimeRst;
            rx_state    <= RX_IDLE;
            bit_pos     <= '0;
            shift_byte  <= '0;
            byte_count  <= '0;
            err_cnt     <= '0;
            restart_cnt <= '0;
            decode_queue.delete();
            pending_q   <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIT_TIME:   bit_time   = i_cfg_data;
                    CFG_TOLERANCE:  tolerance  = i_cfg_data;
                    CFG_START_TIME: start_time = i_cfg_data;
                    default: ;
                endcase
            end

            if (result_ch.valid && result_ch.ready) begin
                if (decode_queue.size() == 0) begin
                    $error("result transfer with no pulse outstanding");
                    fail_total++;
                end else begin
                    oldest = decode_queue.pop_front();
                    check_field("symbol", 8'(oldest.symbol), 8'(result_ch.symbol));
                    check_field("receiving", 8'(oldest.receiving), 8'(result_ch.receiving));
                    check_field("byte_valid", 8'(oldest.byte_valid), 8'(result_ch.byte_valid));
                    check_field("byte_value", oldest.byte_value, result_ch.byte_value);
                    check_field("byte_index", 8'(oldest.byte_index), 8'(result_ch.byte_index));
                    check_field("overflow", 8'(oldest.overflow), 8'(result_ch.overflow));
                    check_field("error_count", oldest.error_count, result_ch.error_count);
                    check_field("restart_count", oldest.restart_count,
                                result_ch.restart_count);
                end
            end

            if (pulse_ch.valid && pulse_ch.ready) begin
                decode_queue.push_back(decode_pulse(pulse_ch.pulse_time));
            end

            pending_q <= decode_queue.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pulse durations and config settings into the OOK pulse-width
// decoder with random stalls on both channels (but for one streaming phase); a side checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import opbd_pkg::*;

    localparam int LimitCycles = 200000;
    localparam int NumPhases   = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [TimeW-1:0]   cfg_data;
    logic               no_stall = 1'b0;

    int pending;
    int fail_count;
    int items_sent = 0;
    int cycles     = 0;
    int bt_cfg;
    int tol_cfg;
    int st_cfg;

    // Directed pulses, reset config: idle ignores, window edges, restarts, one byte
    int directed_pulses[24] = '{
        0, 500, 1000, 65535,
        2000, 400, 599, 600, 900, 1099, 1100, 1899,
        1900, 2099,
        1000, 500, 1000, 500, 500, 1000, 500, 1000,
        65535, 0
    };

    opbd_pulse_if  pulse_if ();
    opbd_result_if result_if ();

    ook_pulse_width_bit_decoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pulse    (pulse_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    opbd_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pulse_ch     (pulse_if),
        .result_ch    (result_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LimitCycles) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_if.ready <= no_stall || ($urandom_range(99) >= 38);
        end
    end

    // Value aimed at the window around nominal; sometimes exactly on or just past an edge
    function automatic logic [TimeW-1:0] pulse_near(int nominal);
        int lo;
        int hi;
        int v;
        lo = nominal - tol_cfg;
        hi = nominal + tol_cfg - 1;
        if (hi < lo) hi = lo;
        case ($urandom_range(9))
            0:       v = lo;
            1:       v = hi;
            2:       v = hi + 1;
            3:       v = lo - 1;
            default: v = lo + int'($urandom_range(hi - lo));
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[TimeW-1:0];
    endfunction

    task automatic send_pulse(input logic [TimeW-1:0] t);
        int idle;
        idle = 0;
        if (!no_stall) begin
            while ($urandom_range(99) < 38) idle++;
        end
        if (idle > 0) begin
            pulse_if.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        pulse_if.valid      <= 1'b1;
        pulse_if.pulse_time <= t;
        do @(posedge i_clk); while (!pulse_if.ready);
        items_sent++;
    endtask

    task automatic send_frame(input int nbits, input bit noisy);
        send_pulse(pulse_near(st_cfg));
        for (int i = 0; i < nbits; i++) begin
            if (noisy && $urandom_range(99) < 12) begin
                send_pulse(TimeW'($urandom_range(0, 65535)));
            end
            send_pulse($urandom_range(1) ? pulse_near(2 * bt_cfg) : pulse_near(bt_cfg));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [TimeW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Only called with the pulse channel drained and no result outstanding
    task automatic set_config(input int bt, input int tol, input int st);
        write_reg(CFG_BIT_TIME, TimeW'(bt));
        write_reg(CFG_TOLERANCE, TimeW'(tol));
        write_reg(CFG_START_TIME, TimeW'(st));
        cfg_we  <= 1'b0;
        bt_cfg  = bt;
        tol_cfg = tol;
        st_cfg  = st;
    endtask

    task automatic drain();
        pulse_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_sequence();
        int r;
        int nbits;
        r = $urandom_range(99);
        if (r < 70) begin
            nbits = ($urandom_range(99) < 70) ? $urandom_range(0, 12) : $urandom_range(13, 40);
            send_frame(nbits, 1'b1);
        end else if (r < 85) begin
            repeat ($urandom_range(1, 30)) send_pulse(TimeW'($urandom_range(0, 65535)));
        end else begin
            repeat ($urandom_range(4, 24)) send_pulse(pulse_near(st_cfg));
        end
    endtask

    initial begin
        int phase_end;
        int budget;
        int bt;
        int tol;
        int st;

        pulse_if.valid      = 1'b0;
        pulse_if.pulse_time = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_BIT_TIME;
        cfg_data = '0;
        i_rst_n  = 1'b0;
        bt_cfg   = int'(BitTimeRst);
        tol_cfg  = int'(ToleranceRst);
        st_cfg   = int'(StartTimeRst);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_pulses[i]) send_pulse(TimeW'(directed_pulses[i]));

        for (int phase = 0; phase < NumPhases; phase++) begin
            case (phase)
                0: begin bt = bt_cfg; tol = tol_cfg; st = st_cfg; budget = 300; end
                1: begin bt = 0;      tol = 0;      st = 0;      budget = 40;  end
                2: begin bt = 65535;  tol = 65535;  st = 65535;  budget = 60;  end
                3: begin bt = 100;    tol = 80;     st = 150;    budget = 100; end
                4: begin bt = 32768;  tol = 1000;   st = 0;      budget = 100; end
                5: begin bt = 10;     tol = 3;      st = 45;     budget = 280; end
                default: begin
                    bt  = $urandom_range(1, 3000);
                    tol = $urandom_range(0, bt);
                    st  = $urandom_range(1) ? 4 * bt : $urandom_range(0, 65535);
                    budget = 90;
                end
            endcase
            if (phase > 0) begin
                drain();
                set_config(bt, tol, st);
            end
            // overlapping-window phase runs with both sides streaming
            no_stall <= (phase == 3);
            phase_end = items_sent + budget;
            // fill the frame to its limit so the remaining bits overflow
            if (phase == 0 || phase == 5) send_frame(8 * MaxBytes + $urandom_range(4, 20), 1'b0);
            while (items_sent < phase_end) run_sequence();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== ook_pulse_width_bit_decoder_top.f =====
rtl/opbd_pkg.sv
rtl/opbd_pulse_if.sv
rtl/opbd_result_if.sv
rtl/opbd_classify.sv
rtl/opbd_queue.sv
rtl/opbd_frame.sv
rtl/ook_pulse_width_bit_decoder_top.sv
test/opbd_decode_checker.sv
test/testbench.sv
